[rtl/aoc_pkg.sv]
// Shared types and constants for the array element offset calculator.
// Request/result payload structs, register map and inter-stage records.
// No dependencies.
`timescale 1ns / 1ps

package aoc_pkg;

  // Field widths fixed by the interface
  localparam int IDX_W    = 16;
  localparam int EXT_W    = 10;
  localparam int ESIZE_W  = 16;
  localparam int OFS_W    = 56;
  localparam int CNT_W    = 2;
  localparam int W0_W     = 2 * EXT_W;
  localparam int P0_W     = IDX_W + W0_W;
  localparam int P1_W     = IDX_W + EXT_W;
  localparam int SUM_W    = P0_W + 1;
  localparam int SCALED_W = SUM_W + ESIZE_W;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DIMS_IN_USE   = 3'd0;
  localparam logic [2:0] REG_LOWER_BOUND_0 = 3'd1;
  localparam logic [2:0] REG_LOWER_BOUND_1 = 3'd2;
  localparam logic [2:0] REG_LOWER_BOUND_2 = 3'd3;
  localparam logic [2:0] REG_EXTENT_0      = 3'd4;
  localparam logic [2:0] REG_EXTENT_1      = 3'd5;
  localparam logic [2:0] REG_EXTENT_2      = 3'd6;
  localparam logic [2:0] REG_ELEMENT_BYTES = 3'd7;

  typedef struct packed {
    logic [CNT_W-1:0] num_indices;
    logic [IDX_W-1:0] index_0;
    logic [IDX_W-1:0] index_1;
    logic [IDX_W-1:0] index_2;
  } req_t;

  typedef struct packed {
    logic [OFS_W-1:0] byte_offset;
    logic [CNT_W-1:0] warn_count;
    logic             index_error;
  } rsp_t;

  typedef struct packed {
    logic [CNT_W-1:0]   dims_in_use;
    logic [IDX_W-1:0]   lower_bound_0;
    logic [IDX_W-1:0]   lower_bound_1;
    logic [IDX_W-1:0]   lower_bound_2;
    logic [EXT_W-1:0]   extent_0;
    logic [EXT_W-1:0]   extent_1;
    logic [EXT_W-1:0]   extent_2;
    logic [ESIZE_W-1:0] element_bytes;
  } cfg_t;

  // Checked request: bound-relative indices and their row-major weights
  typedef struct packed {
    logic             err;
    logic [CNT_W-1:0] warn;
    logic [IDX_W-1:0] diff_0;
    logic [IDX_W-1:0] diff_1;
    logic [IDX_W-1:0] diff_2;
    logic [W0_W-1:0]  weight_0;
    logic [EXT_W-1:0] weight_1;
  } chk_t;

endpackage

[rtl/aoc_regs.sv]
// Configuration register file behind the APB-style port.
// Depends on aoc_pkg for the register map and the cfg_t record.
`timescale 1ns / 1ps

module aoc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aoc_pkg::ADDR_W-1:0] paddr,
  input  logic [aoc_pkg::DATA_W-1:0] pwdata,
  output logic [aoc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output aoc_pkg::cfg_t              cfg
);
  import aoc_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel & penable & pwrite & pready;

  // Write on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dims_in_use   <= CNT_W'(1);
      cfg.lower_bound_0 <= '0;
      cfg.lower_bound_1 <= '0;
      cfg.lower_bound_2 <= '0;
      cfg.extent_0      <= EXT_W'(1);
      cfg.extent_1      <= EXT_W'(1);
      cfg.extent_2      <= EXT_W'(1);
      cfg.element_bytes <= ESIZE_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_DIMS_IN_USE:   cfg.dims_in_use   <= pwdata[CNT_W-1:0];
        REG_LOWER_BOUND_0: cfg.lower_bound_0 <= pwdata[IDX_W-1:0];
        REG_LOWER_BOUND_1: cfg.lower_bound_1 <= pwdata[IDX_W-1:0];
        REG_LOWER_BOUND_2: cfg.lower_bound_2 <= pwdata[IDX_W-1:0];
        REG_EXTENT_0:      cfg.extent_0      <= pwdata[EXT_W-1:0];
        REG_EXTENT_1:      cfg.extent_1      <= pwdata[EXT_W-1:0];
        REG_EXTENT_2:      cfg.extent_2      <= pwdata[EXT_W-1:0];
        REG_ELEMENT_BYTES: cfg.element_bytes <= pwdata[ESIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (reg_idx)
      REG_DIMS_IN_USE:   prdata = DATA_W'(cfg.dims_in_use);
      REG_LOWER_BOUND_0: prdata = DATA_W'(cfg.lower_bound_0);
      REG_LOWER_BOUND_1: prdata = DATA_W'(cfg.lower_bound_1);
      REG_LOWER_BOUND_2: prdata = DATA_W'(cfg.lower_bound_2);
      REG_EXTENT_0:      prdata = DATA_W'(cfg.extent_0);
      REG_EXTENT_1:      prdata = DATA_W'(cfg.extent_1);
      REG_EXTENT_2:      prdata = DATA_W'(cfg.extent_2);
      REG_ELEMENT_BYTES: prdata = DATA_W'(cfg.element_bytes);
      default:           prdata = '0;
    endcase
  end

endmodule

[rtl/aoc_check.sv]
// First pipeline stage: bound checks, lower-bound subtraction and weights.
// Depends on aoc_pkg for req_t, cfg_t and chk_t.
`timescale 1ns / 1ps

module aoc_check #(
  parameter int MAX_DIMS = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  aoc_pkg::req_t request,
  input  aoc_pkg::cfg_t cfg,
  output logic          chk_valid,
  output aoc_pkg::chk_t chk
);
  import aoc_pkg::*;

  logic [CNT_W-1:0] dims;
  logic [IDX_W-1:0] idx [3];
  logic [IDX_W-1:0] lb  [3];
  logic [EXT_W-1:0] ext [3];
  logic [IDX_W-1:0] diff [3];
  logic [2:0]       below;
  logic [2:0]       over;
  chk_t             chk_next;

  // Clamp the dimension count to what the build supports
  assign dims = (cfg.dims_in_use > CNT_W'(MAX_DIMS)) ? CNT_W'(MAX_DIMS) : cfg.dims_in_use;

  assign idx[0] = (request.num_indices > CNT_W'(0)) ? request.index_0 : '0;
  assign idx[1] = (request.num_indices > CNT_W'(1)) ? request.index_1 : '0;
  assign idx[2] = (request.num_indices > CNT_W'(2)) ? request.index_2 : '0;
  assign lb[0]  = cfg.lower_bound_0;
  assign lb[1]  = cfg.lower_bound_1;
  assign lb[2]  = cfg.lower_bound_2;
  assign ext[0] = cfg.extent_0;
  assign ext[1] = cfg.extent_1;
  assign ext[2] = cfg.extent_2;

  // Per-dimension compare and subtract; unused dimensions drop out
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dims > CNT_W'(k)) begin
        below[k] = idx[k] < lb[k];
        over[k]  = {1'b0, idx[k]} >= ({1'b0, lb[k]} + (IDX_W + 1)'(ext[k]));
        diff[k]  = idx[k] - lb[k];
      end else begin
        below[k] = 1'b0;
        over[k]  = 1'b0;
        diff[k]  = '0;
      end
    end
  end

  // Row-major weights: product of the extents of the inner dimensions in use
  always_comb begin
    chk_next.err    = (request.num_indices > dims) | (|below);
    chk_next.warn   = CNT_W'(over[0]) + CNT_W'(over[1]) + CNT_W'(over[2]);
    chk_next.diff_0 = diff[0];
    chk_next.diff_1 = diff[1];
    chk_next.diff_2 = diff[2];
    case (dims)
      2'd3: begin
        chk_next.weight_0 = W0_W'(ext[1]) * W0_W'(ext[2]);
        chk_next.weight_1 = ext[2];
      end
      2'd2: begin
        chk_next.weight_0 = W0_W'(ext[1]);
        chk_next.weight_1 = EXT_W'(1);
      end
      default: begin
        chk_next.weight_0 = W0_W'(1);
        chk_next.weight_1 = EXT_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    chk <= chk_next;
  end

endmodule

[rtl/aoc_scale.sv]
// Back stages: weight products, sum of terms, element-size scaling.
// Depends on aoc_pkg for chk_t and rsp_t.
`timescale 1ns / 1ps

module aoc_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        chk_valid,
  input  aoc_pkg::chk_t               chk,
  input  logic [aoc_pkg::ESIZE_W-1:0] element_bytes,
  output logic                        done,
  output aoc_pkg::rsp_t               result
);
  import aoc_pkg::*;

  // Stage 2 registers
  logic             s2_valid;
  logic             s2_err;
  logic [CNT_W-1:0] s2_warn;
  logic [P0_W-1:0]  s2_p0;
  logic [P1_W-1:0]  s2_p1;
  logic [IDX_W-1:0] s2_d2;
  // Stage 3 registers
  logic             s3_valid;
  logic             s3_err;
  logic [CNT_W-1:0] s3_warn;
  logic [SUM_W-1:0] s3_sum;

  logic [SCALED_W-1:0] scaled;

  assign scaled = SCALED_W'(s3_sum) * SCALED_W'(element_bytes);

  // Advance valid bits every cycle; the receiver never stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s2_valid <= chk_valid;
      s3_valid <= s2_valid;
      done     <= s3_valid;
    end
  end

  // Weight the outer and middle terms
  always_ff @(posedge clk) begin
    s2_err  <= chk.err;
    s2_warn <= chk.warn;
    s2_p0   <= P0_W'(chk.diff_0) * P0_W'(chk.weight_0);
    s2_p1   <= P1_W'(chk.diff_1) * P1_W'(chk.weight_1);
    s2_d2   <= chk.diff_2;
  end

  // Add the three terms
  always_ff @(posedge clk) begin
    s3_err  <= s2_err;
    s3_warn <= s2_warn;
    s3_sum  <= SUM_W'(s2_p0) + SUM_W'(s2_p1) + SUM_W'(s2_d2);
  end

  // Scale by element size; drop offset and warnings on error
  always_ff @(posedge clk) begin
    result.index_error <= s3_err;
    result.warn_count  <= s3_err ? '0 : s3_warn;
    result.byte_offset <= s3_err ? '0 : OFS_W'(scaled);
  end

endmodule

[rtl/array_element_offset_calc.sv]
// Top level of the array element offset calculator.
// Depends on aoc_pkg, aoc_regs, aoc_check and aoc_scale.
//
// Takes one request per clock: busy is never asserted, and each request
// gives exactly one result on the done strobe when it leaves the last of
// the register stages. The four register stages are the bound check
// with the inner-extent product, the two weight multipliers, the three-term
// add, and the element-size multiplier. The receiver cannot stall the result.
// Write configuration only while no request is in flight.
`timescale 1ns / 1ps

module array_element_offset_calc #(
  parameter int MAX_DIMS = 3
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  aoc_pkg::req_t              request,
  output logic                       done,
  output aoc_pkg::rsp_t              result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aoc_pkg::ADDR_W-1:0] paddr,
  input  logic [aoc_pkg::DATA_W-1:0] pwdata,
  output logic [aoc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import aoc_pkg::*;

  cfg_t cfg;
  chk_t chk;
  logic chk_valid;

  // Fully pipelined: always ready for a new request
  assign busy = 1'b0;

  aoc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aoc_check #(
    .MAX_DIMS (MAX_DIMS)
  ) u_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start & ~busy),
    .request   (request),
    .cfg       (cfg),
    .chk_valid (chk_valid),
    .chk       (chk)
  );

  aoc_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .chk_valid     (chk_valid),
    .chk           (chk),
    .element_bytes (cfg.element_bytes),
    .done          (done),
    .result        (result)
  );

endmodule
